// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the radix conversion block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A property checked at every rising edge, ignored while reset is asserted.
`define ITOA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("itoa check failed");
// A condition that must be followed by an expression in the next cycle.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("itoa check failed");
`endif

// ----- src/itoa_pkg.sv -----
// Package of the integer to radix ASCII converter: widths, character codes,
// request and result structs, the command passed from front to back.
// Depends on nothing.
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;

    // One digit per division; radix 2 gives the most digits.
    localparam int STORE_DEPTH = VALUE_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_SIGNED = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(8'h39);
    localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CHAR_Z     = CHAR_W'(8'h7a);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]     base;
        logic                   func;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              empty_res;
    } out_t;

    typedef enum logic [1:0] {
        CMD_EMPTY,
        CMD_ZERO,
        CMD_CONV
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_W-1:0]     base;
        logic                   minus;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > RADIX_W'(9)) begin
            return CHAR_A + d_ext - CHAR_W'(10);
        end
        return CHAR_ZERO + d_ext;
    endfunction

endpackage

// ----- src/itoa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the digit store of the converter.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/itoa_fifo.sv -----
// Short command queue between the front and the back of the converter.
// Depends on itoa_pkg for the command struct and the queue depth.
module itoa_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  itoa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          cmd_valid,
    output itoa_pkg::cmd_t cmd
);
    import itoa_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/itoa_front.sv -----
// Front end of the converter: accepts requests, checks the radix, detects
// zero and negative decimal values and forms the magnitude. Uses itoa_pkg.
module itoa_front (
    input  logic           in_valid,
    output logic           in_stall,
    input  itoa_pkg::in_t  in_data,
    input  logic           queue_full,
    output logic           push,
    output itoa_pkg::cmd_t push_cmd
);
    import itoa_pkg::*;

    logic radix_ok;
    logic is_zero;
    logic is_neg;

    assign radix_ok = (in_data.base >= RADIX_MIN) && (in_data.base <= RADIX_MAX);
    assign is_zero  = (in_data.value == '0);
    // Only a signed decimal request shows a sign; other radixes print raw bits.
    assign is_neg   = in_data.func && (in_data.base == RADIX_SIGNED)
                   && in_data.value[VALUE_WIDTH-1];

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb begin
        push_cmd.base  = in_data.base;
        push_cmd.minus = is_neg;
        push_cmd.mag   = is_neg ? (~in_data.value + VALUE_WIDTH'(1)) : in_data.value;
        if (!radix_ok) begin
            push_cmd.kind = CMD_EMPTY;
        end else if (is_zero) begin
            push_cmd.kind = CMD_ZERO;
        end else begin
            push_cmd.kind = CMD_CONV;
        end
    end

endmodule

// ----- src/itoa_back.sv -----
// Back end of the converter: restoring radix divider, digit store and the
// character output register. Depends on itoa_pkg and itoa_ram.
module itoa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  itoa_pkg::cmd_t cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output itoa_pkg::out_t out_data
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MINUS,
        S_RD,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] quotient_reg, quotient_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_W-1:0]     digit_count_reg, digit_count_next;
    logic                   minus_pending_reg, minus_pending_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    logic [RADIX_W:0]       rem_sh;
    logic [RADIX_W:0]       rem_step;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] quotient_step;
    logic [COUNT_W-1:0]     count_dec;
    logic                   slot_free;

    logic                   wr_en;
    logic                   rd_en;
    logic [RADIX_W-1:0]     rd_data;

    // One quotient bit per cycle: bring down the next dividend bit.
    assign rem_sh        = {rem_reg, quotient_reg[VALUE_WIDTH-1]};
    assign ge            = (rem_sh >= {1'b0, base_reg});
    assign rem_step      = ge ? (rem_sh - {1'b0, base_reg}) : rem_sh;
    assign quotient_step = {quotient_reg[VALUE_WIDTH-2:0], ge};
    assign count_dec     = digit_count_reg - COUNT_W'(1);
    assign slot_free     = !out_valid_reg || !out_stall;

    itoa_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (digit_count_reg[ADDR_W-1:0]),
        .wr_data (rem_step[RADIX_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (count_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next         = state_reg;
        quotient_next      = quotient_reg;
        rem_next           = rem_reg;
        base_next          = base_reg;
        step_next          = step_reg;
        digit_count_next   = digit_count_reg;
        minus_pending_next = minus_pending_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_data_next      = out_data_reg;
        pop                = 1'b0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        CMD_CONV: begin
                            pop                = 1'b1;
                            quotient_next      = cmd.mag;
                            base_next          = cmd.base;
                            minus_pending_next = cmd.minus;
                            rem_next           = '0;
                            step_next          = '0;
                            digit_count_next   = '0;
                            state_next         = S_DIV;
                        end
                        CMD_ZERO: begin
                            if (slot_free) begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '{char_code: CHAR_ZERO, last: 1'b1,
                                                   empty_res: 1'b0};
                            end
                        end
                        CMD_EMPTY: begin
                            if (slot_free) begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '{char_code: CHAR_NONE, last: 1'b1,
                                                   empty_res: 1'b1};
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                quotient_next = quotient_step;
                rem_next      = rem_step[RADIX_W-1:0];
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_WIDTH - 1)) begin
                    // Digit complete: store the remainder, start over on the quotient.
                    wr_en            = 1'b1;
                    digit_count_next = digit_count_reg + COUNT_W'(1);
                    rem_next         = '0;
                    step_next        = '0;
                    if (quotient_step == '0) begin
                        state_next = minus_pending_reg ? S_MINUS : S_RD;
                    end
                end
            end
            S_MINUS: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{char_code: CHAR_MINUS, last: 1'b0, empty_res: 1'b0};
                    state_next     = S_RD;
                end
            end
            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    out_valid_next   = 1'b1;
                    out_data_next    = '{char_code: digit_char(rd_data),
                                         last: (digit_count_reg == COUNT_W'(1)),
                                         empty_res: 1'b0};
                    digit_count_next = count_dec;
                    state_next       = (digit_count_reg == COUNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg         <= S_IDLE;
            quotient_reg      <= '0;
            rem_reg           <= '0;
            base_reg          <= '0;
            step_reg          <= '0;
            digit_count_reg   <= '0;
            minus_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end else begin
            state_reg         <= state_next;
            quotient_reg      <= quotient_next;
            rem_reg           <= rem_next;
            base_reg          <= base_next;
            step_reg          <= step_next;
            digit_count_reg   <= digit_count_next;
            minus_pending_reg <= minus_pending_next;
            out_valid_reg     <= out_valid_next;
            out_data_reg      <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/integer_to_radix_ascii.sv -----
// Top level of the integer to radix ASCII converter.
// Depends on itoa_pkg, itoa_front, itoa_fifo and itoa_back.
//
// Usage: a request carries a 32-bit value, a radix and a signed selector on
// the in channel (in_valid, in_stall, in_data). The result channel (out_valid,
// out_stall, out_data) returns one ASCII character per transfer, most
// significant digit first, with last set on the final character. A signed
// decimal request with the sign bit set starts with a minus. A zero value
// returns the single character '0'; a radix outside 2 to 36 returns one
// result with empty_res and last set and a zero character code.
// Timing: the radix divider is a shared restoring unit that produces one
// quotient bit per cycle, and each character then passes through the
// registered read of the digit store before it reaches the output register.
// Zero and invalid radix requests are popped from the queue as their single
// result is registered, once the output register is free.
// The front end accepts a request every cycle while the two-entry command
// queue has room, so requests can be taken while a conversion is running.
// Reset empties the queue and the output register and returns the back end
// to idle. A stalled receiver holds the current character in the output
// register; the back end waits and the queue fills, then in_stall rises.
module integer_to_radix_ascii (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  itoa_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output itoa_pkg::out_t out_data
);
    import itoa_pkg::*;

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic cmd_valid;
    cmd_t cmd;

    // Classification of each request happens in the same cycle it is taken.
    itoa_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // The queue decouples request acceptance from the long conversions.
    itoa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Divider, digit store and character output register.
    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- src/itoa_checker.sv -----
// Port-level checks of the integer to radix ASCII converter and its bind.
// Depends on itoa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itoa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input itoa_pkg::out_t out_data
);
    import itoa_pkg::*;

    // A stalled result stays offered and unchanged.
    `ITOA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // An empty result is a lone zero code that closes its conversion.
    `ITOA_ASSERT(a_empty_form, clk, rst_n, (out_valid && out_data.empty_res) |-> (out_data.last && (out_data.char_code == CHAR_NONE)))

    // Normal results carry only digits, lowercase letters or a minus.
    `ITOA_ASSERT(a_char_set, clk, rst_n, (out_valid && !out_data.empty_res) |-> (((out_data.char_code >= CHAR_ZERO) && (out_data.char_code <= CHAR_NINE)) || ((out_data.char_code >= CHAR_A) && (out_data.char_code <= CHAR_Z)) || (out_data.char_code == CHAR_MINUS)))

    // A minus is always followed by at least one digit.
    `ITOA_ASSERT(a_minus_not_last, clk, rst_n, (out_valid && (out_data.char_code == CHAR_MINUS)) |-> !out_data.last)

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- tb/sv/integer_to_radix_ascii_tb.sv -----
// Testbench of the integer to radix ASCII converter: directed and random requests
// checked character by character against a predictor kept inside this file.
// Depends on itoa_pkg and the integer_to_radix_ascii top level.
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;

    import itoa_pkg::*;

    localparam int  RESET_CYCLES = 6;
    localparam int  MAX_GAP      = 20;
    // The drain at the end waits longer than a full radix-2 conversion holds the
    // back end, so that stray characters are still caught.
    localparam int  DRAIN_CYCLES = 1200;
    localparam int  HOLD_CYCLES  = 400;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    // Characters still to come, oldest first, across all accepted requests.
    out_t   expected_chars[$];
    int     mismatch_count = 0;
    int     send_idle_pct  = 0;
    int     stall_pct      = 0;
    logic   hold_active    = 1'b0;
    longint cycle_count    = 0;

    integer_to_radix_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Build the ASCII character of one digit value.
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        if (d >= RADIX_SIGNED) begin
            return CHAR_A + CHAR_W'(d - RADIX_SIGNED);
        end
        return CHAR_ZERO + CHAR_W'(d);
    endfunction

    // Work out every character that one accepted request produces and queue it.
    function automatic void predict_chars(input in_t req);
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_W-1:0]     digits[VALUE_WIDTH];
        int                     ndig;
        logic                   neg;
        out_t                   ch;
        ndig = 0;
        // An invalid radix yields one empty marker and nothing else.
        if (req.base < RADIX_MIN || req.base > RADIX_MAX) begin
            ch.char_code = CHAR_NONE;
            ch.last      = 1'b1;
            ch.empty_res = 1'b1;
            expected_chars.push_back(ch);
            return;
        end
        ch.empty_res = 1'b0;
        if (req.value == '0) begin
            ch.char_code = CHAR_ZERO;
            ch.last      = 1'b1;
            expected_chars.push_back(ch);
            return;
        end
        // Only signed decimal honors the sign bit; the negation wraps, so the
        // most negative value keeps its full magnitude as an unsigned number.
        neg = req.func && (req.base == RADIX_SIGNED) && req.value[VALUE_WIDTH-1];
        mag = neg ? (~req.value + 1'b1) : req.value;
        while (mag != '0) begin
            digits[ndig] = RADIX_W'(mag % req.base);
            mag          = mag / req.base;
            ndig++;
        end
        if (neg) begin
            ch.char_code = CHAR_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            ch.char_code = digit_ascii(digits[i]);
            ch.last      = (i == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic in_t make_req(input logic [VALUE_WIDTH-1:0] value,
                                     input logic [RADIX_W-1:0] base, input logic func);
        in_t req;
        req.value = value;
        req.base  = base;
        req.func  = func;
        return req;
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays high
    // into the next request when no gap is drawn, so it is never lowered and
    // raised within one time step.
    task automatic send_request(input in_t req);
        int gap;
        gap = 0;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predict_chars(req);
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random request: mostly valid radixes, values spread over small numbers,
    // full-range words, negative words and powers of two near the boundaries.
    function automatic in_t random_req();
        in_t req;
        case ($urandom_range(3))
            0: req.value = $urandom;
            1: req.value = $urandom_range(0, 40);
            2: req.value = {1'b1, 31'($urandom)};
            default: req.value = (VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1))
                                 - VALUE_WIDTH'($urandom_range(1));
        endcase
        if ($urandom_range(9) == 0) begin
            req.base = $urandom_range(1) ? RADIX_W'($urandom_range(0, 1))
                                         : RADIX_W'($urandom_range(37, 63));
        end else begin
            req.base = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        end
        // Bias toward radix 10 so the signed path gets real traffic.
        if ($urandom_range(3) == 0) begin
            req.base = RADIX_SIGNED;
        end
        req.func = $urandom_range(1);
        return req;
    endfunction

    // Hold the receiver off for a long stretch, counted here on its own.
    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_active <= 1'b0;
    endtask

    task automatic test_invalid_radix();
        send_request(make_req(32'd1234, RADIX_W'(0), 1'b0));
        send_request(make_req(32'd5, RADIX_W'(1), 1'b1));
        send_request(make_req(32'hffff_ffff, RADIX_W'(37), 1'b0));
        send_request(make_req(32'h8000_0000, RADIX_W'(63), 1'b1));
    endtask

    task automatic test_zero_value();
        send_request(make_req(32'd0, RADIX_MIN, 1'b0));
        send_request(make_req(32'd0, RADIX_SIGNED, 1'b1));
        send_request(make_req(32'd0, RADIX_MAX, 1'b1));
    endtask

    task automatic test_extreme_values();
        // Radix 2 of all ones gives the longest string.
        send_request(make_req(32'hffff_ffff, RADIX_MIN, 1'b0));
        send_request(make_req(32'hffff_ffff, RADIX_MAX, 1'b0));
        send_request(make_req(32'hffff_ffff, RADIX_SIGNED, 1'b0));
        send_request(make_req(32'hffff_ffff, RADIX_SIGNED, 1'b1));
        // Most negative value in signed decimal, then the same bits in hex.
        send_request(make_req(32'h8000_0000, RADIX_SIGNED, 1'b1));
        send_request(make_req(32'h8000_0000, RADIX_W'(16), 1'b1));
        send_request(make_req(32'h7fff_ffff, RADIX_SIGNED, 1'b1));
        send_request(make_req(32'd1, RADIX_MIN, 1'b1));
        send_request(make_req(32'd35, RADIX_MAX, 1'b0));
        send_request(make_req(32'd10, RADIX_W'(11), 1'b0));
        send_request(make_req(32'hdead_beef, RADIX_W'(16), 1'b0));
    endtask

    task automatic test_random_requests(input int count, input int send_pct,
                                        input int recv_pct);
        send_idle_pct <= send_pct;
        stall_pct     <= recv_pct;
        repeat (count) begin
            send_request(random_req());
        end
    endtask

    // The receiver stalls for a long time while requests keep coming, so the
    // command queue fills and in_stall has to rise.
    task automatic test_backpressure();
        send_idle_pct <= 0;
        stall_pct     <= 0;
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        repeat (20) begin
            send_request(random_req());
        end
    endtask

    // Each accepted character is checked against the oldest expectation; the
    // stall for the next edge is drawn after the sample.
    always @(posedge clk) begin : result_check
        out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_data.char_code !== want.char_code) begin
                    $display("%0t: char_code mismatch, expected %h, actual %h",
                             $time, want.char_code, out_data.char_code);
                    mismatch_count++;
                end
                if (out_data.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want.last, out_data.last);
                    mismatch_count++;
                end
                if (out_data.empty_res !== want.empty_res) begin
                    $display("%0t: empty_res mismatch, expected %b, actual %b",
                             $time, want.empty_res, out_data.empty_res);
                    mismatch_count++;
                end
            end
        end
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_invalid_radix();
        test_zero_value();
        test_extreme_values();
        test_random_requests(105, 0, 0);
        test_random_requests(105, 51, 0);
        test_random_requests(105, 0, 51);
        test_random_requests(105, 28, 28);
        test_backpressure();
        in_valid <= 1'b0;

        while (expected_chars.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/itoa_pkg.sv
src/itoa_ram.sv
src/itoa_fifo.sv
src/itoa_front.sv
src/itoa_back.sv
src/integer_to_radix_ascii.sv
src/itoa_checker.sv
tb/sv/integer_to_radix_ascii_tb.sv
